@@ design/conv2d_3x3_border_modes_macros.svh @@
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef CONV2D_3X3_BORDER_MODES_MACROS_SVH
`define CONV2D_3X3_BORDER_MODES_MACROS_SVH

// same-cycle implication
`define C3BM_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("c3bm assertion failed");

// next-cycle implication
`define C3BM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("c3bm assertion failed");

`endif

@@ design/c3bm_pkg.sv @@
package c3bm_pkg;

    localparam int KERNEL        = 3;
    localparam int TAPS          = KERNEL * KERNEL;
    localparam int C3BM_MAX_LINE  = 1024;
    localparam int C3BM_MAX_LINES = 1024;

    localparam int PIX_W      = 8;
    localparam int WEIGHT_W   = 16;
    localparam int PROD_W     = WEIGHT_W + PIX_W + 1;
    localparam int SUM_W      = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_SIZE_W = 11;
    localparam int MIN_SIZE   = 3;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [KERNEL-1:0][PIX_W-1:0] col_t;   // [0] top, [1] mid, [2] low
    typedef logic [TAPS-1:0][PIX_W-1:0] taps_t;    // index row*KERNEL + column
    typedef logic [CFG_DATA_W-1:0] wrow_t;

    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BORDER_MODE  = 3'd0,
        CFG_PIXEL_OFFSET = 3'd1,
        CFG_LINE_LENGTH  = 3'd2,
        CFG_LINE_TOTAL   = 3'd3,
        CFG_WEIGHTS_TOP  = 3'd4,
        CFG_WEIGHTS_MID  = 3'd5,
        CFG_WEIGHTS_LOW  = 3'd6
    } cfg_idx_t;

    localparam logic [1:0] MODE_ZERO   = 2'd0;
    localparam logic [1:0] MODE_WHITE  = 2'd1;
    localparam logic [1:0] MODE_REPL   = 2'd2;
    localparam logic [1:0] MODE_MIRROR = 2'd3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam wrow_t WEIGHTS_MID_RESET = 48'd256;

    function automatic int clamp_size(input logic [CFG_SIZE_W-1:0] v, input int hi);
        int x;
        x = int'(v);
        if (x < MIN_SIZE) return MIN_SIZE;
        if (x > hi) return hi;
        return x;
    endfunction

    // column 0 is c-1, 1 is c, 2 is c+1
    function automatic logic signed [WEIGHT_W-1:0] weight_of(input wrow_t w, input int col);
        logic signed [WEIGHT_W-1:0] r;
        case (col)
            0:       r = w[31:16];
            1:       r = w[15:0];
            default: r = w[47:32];
        endcase
        return r;
    endfunction

endpackage

@@ design/c3bm_if.sv @@
interface c3bm_in_if import c3bm_pkg::*;;
    logic valid;
    logic ready;
    logic command;
    pix_t pixel_in;
    modport source (output valid, output command, output pixel_in, input ready);
    modport sink (input valid, input command, input pixel_in, output ready);
endinterface

interface c3bm_out_if import c3bm_pkg::*;;
    logic valid;
    logic ready;
    pix_t pixel_out;
    logic frame_end;
    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

@@ design/conv2d_3x3_border_modes.sv @@
// 3x3 border-padded convolution over a scan-order pixel stream. Takes one
// transfer per clock and gives one result per clock whenever the output
// side is ready; a stalled output holds the whole three-stage pipeline
// (tap select, nine multipliers, sum and clamp); a result passes through
// them in order after the transfer that completes its neighborhood. The result
// for position k comes with the transfer of stream position
// k + line_length + 1; after the last pixel of a frame, line_length + 1
// more transfers (drain or pixel, data ignored) flush the remaining
// outputs, the last one carrying frame_end. A drain sent inside the frame
// is taken and ignored. Writing line_length or line_total restarts the
// frame. Two line memories of MAX_LINE pixels hold the previous two lines.
`include "conv2d_3x3_border_modes_macros.svh"

module conv2d_3x3_border_modes import c3bm_pkg::*;
#(
    parameter int MAX_LINE  = C3BM_MAX_LINE,
    parameter int MAX_LINES = C3BM_MAX_LINES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    c3bm_in_if.sink               in_ch,
    c3bm_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_LINE + 1);
    localparam int AW = $clog2(MAX_LINE);
    localparam int RW = $clog2(MAX_LINES + 2);

    // configuration registers
    logic [1:0]            border_mode_reg;
    pix_t                  pixel_offset_reg;
    logic [CFG_SIZE_W-1:0] line_length_reg;
    logic [CFG_SIZE_W-1:0] line_total_reg;
    wrow_t                 w_top_reg;
    wrow_t                 w_mid_reg;
    wrow_t                 w_low_reg;

    logic [CW-1:0] len_eff;
    logic [RW-1:0] lines_eff;

    // stream position counters
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic en, accept, ignored, step, produce, last, restart_cfg;
    logic in_col_wrap, out_col_wrap;

    pix_t  lb1_rd, lb2_rd;
    col_t  new_col, w1, w2;
    col_t  cols [KERNEL];
    logic  row_out [KERNEL];
    logic  col_out [KERNEL];
    logic  pad_mode;
    pix_t  pad_val;
    taps_t taps;
    taps_t taps_reg;
    ctl_t  s1_ctl_reg;
    ctl_t  out_ctl;
    pix_t  out_pix;

    assign len_eff   = CW'(clamp_size(line_length_reg, MAX_LINE));
    assign lines_eff = RW'(clamp_size(line_total_reg, MAX_LINES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_mode_reg  <= MODE_ZERO;
            pixel_offset_reg <= '0;
            line_length_reg  <= CFG_SIZE_W'(MIN_SIZE);
            line_total_reg   <= CFG_SIZE_W'(MIN_SIZE);
            w_top_reg        <= '0;
            w_mid_reg        <= WEIGHTS_MID_RESET;
            w_low_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BORDER_MODE:  border_mode_reg  <= cfg_data[1:0];
                CFG_PIXEL_OFFSET: pixel_offset_reg <= cfg_data[PIX_W-1:0];
                CFG_LINE_LENGTH:  line_length_reg  <= cfg_data[CFG_SIZE_W-1:0];
                CFG_LINE_TOTAL:   line_total_reg   <= cfg_data[CFG_SIZE_W-1:0];
                CFG_WEIGHTS_TOP:  w_top_reg        <= cfg_data;
                CFG_WEIGHTS_MID:  w_mid_reg        <= cfg_data;
                CFG_WEIGHTS_LOW:  w_low_reg        <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign restart_cfg = cfg_we && (cfg_index == CFG_LINE_LENGTH || cfg_index == CFG_LINE_TOTAL);

    // the pipeline moves as a whole whenever the output register can drain
    assign en           = !out_ch.valid || out_ch.ready;
    assign in_ch.ready  = en;
    assign accept       = in_ch.valid && en;
    // a drain inside the frame is taken but changes nothing
    assign ignored      = (in_row_reg < lines_eff) && (in_ch.command == CMD_DRAIN);
    assign step         = accept && !ignored;
    // first output once stream position reaches line_length + 1
    assign produce      = step && ((in_row_reg >= RW'(2))
                          || (in_row_reg == RW'(1) && in_col_reg != '0));
    assign in_col_wrap  = in_col_reg == len_eff - CW'(1);
    assign out_col_wrap = out_col_reg == len_eff - CW'(1);
    assign last         = (out_row_reg == lines_eff - RW'(1)) && out_col_wrap;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart_cfg || (produce && last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (step)
        begin
            in_col_next = in_col_wrap ? '0 : in_col_reg + CW'(1);
            in_row_next = in_col_wrap ? in_row_reg + RW'(1) : in_row_reg;
            if (produce)
            begin
                out_col_next = out_col_wrap ? '0 : out_col_reg + CW'(1);
                out_row_next = out_col_wrap ? out_row_reg + RW'(1) : out_row_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // line memories read ahead at the next column, so read data always
    // matches the current column; lb1 is the line above, lb2 two lines up
    c3bm_line_mem #(.DEPTH(MAX_LINE), .AW(AW)) u_lb1 (
        .clk   (clk),
        .we    (step),
        .waddr (in_col_reg[AW-1:0]),
        .wdata (in_ch.pixel_in),
        .raddr (in_col_next[AW-1:0]),
        .rdata (lb1_rd)
    );

    c3bm_line_mem #(.DEPTH(MAX_LINE), .AW(AW)) u_lb2 (
        .clk   (clk),
        .we    (step),
        .waddr (in_col_reg[AW-1:0]),
        .wdata (lb1_rd),
        .raddr (in_col_next[AW-1:0]),
        .rdata (lb2_rd)
    );

    // window chain: new column -> w2 -> w1
    assign new_col = {in_ch.pixel_in, lb1_rd, lb2_rd};

    c3bm_win_cell u_cell_2 (
        .clk (clk),
        .en  (step),
        .d   (new_col),
        .q   (w2)
    );

    c3bm_win_cell u_cell_1 (
        .clk (clk),
        .en  (step),
        .d   (w2),
        .q   (w1)
    );

    always_comb
    begin
        case (border_mode_reg) inside
            MODE_ZERO:              begin pad_mode = 1'b1; pad_val = '0;    end
            MODE_WHITE:             begin pad_mode = 1'b1; pad_val = 8'hFF; end
            MODE_REPL, MODE_MIRROR: begin pad_mode = 1'b0; pad_val = '0;    end
            default:                begin pad_mode = 1'b0; pad_val = '0;    end
        endcase
    end

    // center column is always w2; at the start of a line the output belongs
    // to the end of the previous line and the window has not shifted yet
    always_comb
    begin
        cols[1] = w2;
        if (in_col_reg == '0)
        begin
            cols[0] = w1;
            cols[2] = w2;
        end
        else
        begin
            cols[0] = (in_col_reg == CW'(1)) ? w2 : w1;
            cols[2] = new_col;
        end
        row_out[0] = out_row_reg == '0;
        row_out[1] = 1'b0;
        row_out[2] = out_row_reg == lines_eff - RW'(1);
        col_out[0] = out_col_reg == '0;
        col_out[1] = 1'b0;
        col_out[2] = out_col_wrap;
        for (int r = 0; r < KERNEL; r++)
        begin
            for (int c = 0; c < KERNEL; c++)
            begin
                if (pad_mode && (row_out[r] || col_out[c]))
                    taps[r*KERNEL+c] = pad_val;
                else if (row_out[r])
                    taps[r*KERNEL+c] = cols[c][1];
                else
                    taps[r*KERNEL+c] = cols[c][r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            taps_reg <= taps;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg.valid <= produce;
            s1_ctl_reg.last  <= produce && last;
        end
    end

    c3bm_filter u_filter (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .taps    (taps_reg),
        .in_ctl  (s1_ctl_reg),
        .w_top   (w_top_reg),
        .w_mid   (w_mid_reg),
        .w_low   (w_low_reg),
        .offset  (pixel_offset_reg),
        .pixel   (out_pix),
        .out_ctl (out_ctl)
    );

    assign out_ch.valid     = out_ctl.valid;
    assign out_ch.pixel_out = out_pix;
    assign out_ch.frame_end = out_ctl.last;

    `C3BM_ASSERT_IMPL(a_col_range, 1'b1, in_col_reg < len_eff && out_col_reg < len_eff)
    `C3BM_ASSERT_NEXT(a_frame_restart, produce && last,
        in_row_reg == '0 && out_row_reg == '0 && out_col_reg == '0)
    `C3BM_ASSERT_NEXT(a_stall_hold, !en, $stable(taps_reg) && $stable(s1_ctl_reg))
    `C3BM_ASSERT_IMPL(a_no_early_out, step && in_row_reg == '0, !produce)

endmodule

@@ design/c3bm_line_mem.sv @@
module c3bm_line_mem import c3bm_pkg::*;
#(
    parameter int DEPTH = C3BM_MAX_LINE,
    parameter int AW    = $clog2(C3BM_MAX_LINE)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  pix_t          wdata,
    input  logic [AW-1:0] raddr,
    output pix_t          rdata
);

    pix_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ design/c3bm_win_cell.sv @@
module c3bm_win_cell import c3bm_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  col_t d,
    output col_t q
);

    col_t col_reg;

    // one window column, shifted toward the older neighbor on each step
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= d;
        end
    end

    assign q = col_reg;

endmodule

@@ design/c3bm_filter.sv @@
module c3bm_filter import c3bm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  taps_t      taps,
    input  ctl_t       in_ctl,
    input  wrow_t      w_top,
    input  wrow_t      w_mid,
    input  wrow_t      w_low,
    input  pix_t       offset,
    output pix_t       pixel,
    output ctl_t       out_ctl
);

    logic signed [PROD_W-1:0] prod_reg [TAPS];
    logic signed [PROD_W-1:0] prod_next [TAPS];
    ctl_t prod_ctl_reg;
    pix_t pix_reg;
    pix_t pix_next;
    ctl_t out_ctl_reg;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] quot;

    always_comb
    begin
        for (int r = 0; r < KERNEL; r++)
        begin
            for (int c = 0; c < KERNEL; c++)
            begin
                prod_next[r*KERNEL+c] = weight_of((r == 0) ? w_top : ((r == 1) ? w_mid : w_low), c)
                    * $signed({1'b0, taps[r*KERNEL+c]});
            end
        end
    end

    // offset in 1/256 units plus the rounding half
    always_comb
    begin
        sum = $signed({{(SUM_W-16){1'b0}}, offset, 8'd128});
        for (int i = 0; i < TAPS; i++)
        begin
            sum = sum + SUM_W'(prod_reg[i]);
        end
        quot = sum >>> 8;
        if (sum < 0)
            pix_next = '0;
        else if (quot > SUM_W'(255))
            pix_next = 8'hFF;
        else
            pix_next = quot[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            pix_reg  <= pix_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctl_reg <= '0;
            out_ctl_reg  <= '0;
        end
        else if (en)
        begin
            prod_ctl_reg <= in_ctl;
            out_ctl_reg  <= prod_ctl_reg;
        end
    end

    assign pixel   = pix_reg;
    assign out_ctl = out_ctl_reg;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import c3bm_pkg::*;

    localparam int HIST_DEPTH  = 2 * C3BM_MAX_LINE + 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 12;

    // model of the filter: line history, counters and registers of its own
    class conv_scoreboard;
        typedef struct {
            logic [7:0] pix;
            logic       last;
        } filtered_t;

        filtered_t   expected_pixels[$];
        logic [7:0]  history[HIST_DEPTH];
        int          in_col, in_row, out_col, out_row;
        logic [1:0]  mode;
        int          offset;
        logic [10:0] len_reg, lines_reg;
        logic [47:0] weights[3];
        int          errors;

        function new();
            mode = MODE_ZERO;
            offset = 0;
            len_reg = 11'd3;
            lines_reg = 11'd3;
            weights[0] = '0;
            weights[1] = WEIGHTS_MID_RESET;
            weights[2] = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int eff_size(logic [10:0] v);
            if (v < 3) return 3;
            if (v > C3BM_MAX_LINE) return C3BM_MAX_LINE;
            return int'(v);
        endfunction

        function void set_reg(cfg_idx_t idx, logic [47:0] v);
            case (idx)
                CFG_BORDER_MODE:  mode = v[1:0];
                CFG_PIXEL_OFFSET: offset = int'(v[7:0]);
                CFG_LINE_LENGTH:
                begin
                    len_reg = v[10:0];
                    restart();
                end
                CFG_LINE_TOTAL:
                begin
                    lines_reg = v[10:0];
                    restart();
                end
                CFG_WEIGHTS_TOP:  weights[0] = v;
                CFG_WEIGHTS_MID:  weights[1] = v;
                CFG_WEIGHTS_LOW:  weights[2] = v;
                default: ;
            endcase
        endfunction

        // coefficient for row offset dr, column offset dc
        function longint coeff(int dr, int dc);
            logic [47:0] w;
            w = weights[dr + 1];
            if (dc < 0) return longint'($signed(w[31:16]));
            if (dc == 0) return longint'($signed(w[15:0]));
            return longint'($signed(w[47:32]));
        endfunction

        function void note_input(logic cmd, logic [7:0] pix);
            int         len, lines, pos, rr, cc;
            longint     acc;
            logic [7:0] v;
            filtered_t  res;
            bit         edge_out;
            len = eff_size(len_reg);
            lines = eff_size(lines_reg);
            pos = in_row * len + in_col;
            if (in_row < lines)
            begin
                // drain inside the frame is ignored
                if (cmd == CMD_DRAIN) return;
                history[pos % HIST_DEPTH] = pix;
            end
            in_col++;
            if (in_col >= len)
            begin
                in_col = 0;
                in_row++;
            end
            if (pos < len + 1) return;
            acc = longint'(offset) * 256;
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    rr = out_row + dr;
                    cc = out_col + dc;
                    edge_out = !(rr >= 0 && rr < lines && cc >= 0 && cc < len);
                    if (edge_out && mode == MODE_ZERO)
                        v = 8'd0;
                    else if (edge_out && mode == MODE_WHITE)
                        v = 8'd255;
                    else
                    begin
                        if (rr < 0) rr = 0;
                        if (rr >= lines) rr = lines - 1;
                        if (cc < 0) cc = 0;
                        if (cc >= len) cc = len - 1;
                        v = history[(rr * len + cc) % HIST_DEPTH];
                    end
                    acc += coeff(dr, dc) * longint'(v);
                end
            end
            acc += 128;
            if (acc < 0)
                res.pix = 8'd0;
            else
            begin
                acc = acc / 256;
                res.pix = (acc > 255) ? 8'd255 : acc[7:0];
            end
            res.last = (out_row == lines - 1) && (out_col == len - 1);
            expected_pixels.push_back(res);
            out_col++;
            if (out_col >= len)
            begin
                out_col = 0;
                out_row++;
            end
            if (res.last) restart();
        endfunction

        function void check(logic [7:0] pix, logic last);
            filtered_t exp_px;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: pixel_out=%0d frame_end=%0b", pix, last);
                return;
            end
            exp_px = expected_pixels.pop_front();
            if (pix !== exp_px.pix || last !== exp_px.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected pixel_out=%0d frame_end=%0b, got %0d %0b",
                             exp_px.pix, exp_px.last, pix, last);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    c3bm_in_if  in_ch();
    c3bm_out_if out_ch();

    conv2d_3x3_border_modes dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    conv_scoreboard sb = new();

    // when set, neither side inserts gaps or stalls
    bit     no_idle;
    int     cycles;
    int     stall_left;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: check each transfer, then choose ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check(out_ch.pixel_out, out_ch.frame_end);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            stall_left <= pick_gap();
            out_ch.ready <= 1'b1;
        end
    end

    // one input transfer, with an optional gap in front
    task automatic send_item(logic cmd, logic [7:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.pixel_in <= pix;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(cmd, pix);
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // block is idle once every result is out and the pipeline has emptied
    task automatic wait_drained();
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [47:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic set_config(logic [1:0] m, logic [7:0] off, logic [10:0] len,
                              logic [10:0] lines, logic [47:0] wt, logic [47:0] wm,
                              logic [47:0] wl);
        stop_sending();
        wait_drained();
        write_reg(CFG_BORDER_MODE, 48'(m));
        write_reg(CFG_PIXEL_OFFSET, 48'(off));
        write_reg(CFG_LINE_LENGTH, 48'(len));
        write_reg(CFG_LINE_TOTAL, 48'(lines));
        write_reg(CFG_WEIGHTS_TOP, wt);
        write_reg(CFG_WEIGHTS_MID, wm);
        write_reg(CFG_WEIGHTS_LOW, wl);
        repeat (2) @(posedge clk);
    endtask

    // whole frame with random content; noise adds ignored drains mid-frame
    task automatic send_frame(int noise);
        int len, lines;
        len = sb.eff_size(sb.len_reg);
        lines = sb.eff_size(sb.lines_reg);
        for (int i = 0; i < len * lines; i++)
        begin
            if (noise > 0 && $urandom_range(0, 99) < noise)
                send_item(CMD_DRAIN, 8'($urandom));
            send_item(CMD_PIXEL, 8'($urandom));
        end
        // flush; a pixel here is taken as a drain
        for (int i = 0; i <= len; i++)
            send_item($urandom_range(0, 3) != 0, 8'($urandom));
    endtask

    // small random coefficient, packed three to a row
    function automatic logic [47:0] mild_row();
        logic [47:0] w;
        for (int k = 0; k < 3; k++)
            w[k*16 +: 16] = 16'($signed($urandom_range(0, 200)) - 100);
        return w;
    endfunction

    initial
    begin
        int         len;
        logic [7:0] corner;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_PIXEL;
        in_ch.pixel_in = '0;
        out_ch.ready = 1'b0;
        cycles = 0;
        stall_left = 0;
        no_idle = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings are identity on a 3x3 frame
        send_item(CMD_DRAIN, 8'hff);           // drain at frame start, ignored
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'hff);
        send_item(CMD_PIXEL, 8'h55);
        send_item(CMD_DRAIN, 8'h00);           // drain inside the frame, ignored
        send_item(CMD_PIXEL, 8'haa);
        send_item(CMD_PIXEL, 8'h01);
        send_item(CMD_PIXEL, 8'h80);
        send_item(CMD_PIXEL, 8'h7f);
        send_item(CMD_PIXEL, 8'hfe);
        send_item(CMD_PIXEL, 8'h00);
        send_item(CMD_PIXEL, 8'h12);           // pixel during flush, data dropped
        send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_DRAIN, 8'h00);
        send_item(CMD_DRAIN, 8'h00);

        // white border, top offset, strong positive and negative taps
        set_config(MODE_WHITE, 8'd150, 11'd3, 11'd3,
                   48'h7fff_8000_0100, 48'h0080_ff00_7fff, 48'h8000_7fff_ffff);
        corner = 8'hff;
        for (int i = 0; i < 9; i++)
        begin
            send_item(CMD_PIXEL, corner);
            corner = ~corner;
        end
        for (int i = 0; i < 4; i++)
            send_item(CMD_DRAIN, 8'h00);

        // pause until every result is back, then continue in the same setting
        stop_sending();
        while (sb.pending() > 0) @(posedge clk);
        send_frame(0);

        // random part: small frames over all border modes
        for (int ph = 0; ph < 8; ph++)
        begin
            no_idle = (ph % 5 == 4);
            set_config(2'(ph % 4),
                       (ph % 3 == 0) ? 8'd0 : (ph % 3 == 1) ? 8'd150 : 8'($urandom_range(0, 150)),
                       (ph % 7 == 0) ? 11'd0 : 11'($urandom_range(3, 7)),
                       (ph % 6 == 1) ? 11'd2 : 11'($urandom_range(3, 5)),
                       (ph % 2) ? 48'($urandom) | (48'($urandom) << 32) : mild_row(),
                       (ph % 2) ? mild_row() : 48'($urandom) | (48'($urandom) << 16),
                       (ph % 3 == 2) ? 48'hffff_ffff_ffff : mild_row());
            send_frame(6);
            // broken frame: two lines and two pixels, then a size write restarts it
            if (ph % 4 == 3)
            begin
                len = sb.eff_size(sb.len_reg);
                for (int i = 0; i < 2 * len + 2; i++)
                    send_item(CMD_PIXEL, 8'($urandom));
                stop_sending();
                wait_drained();
                write_reg(CFG_LINE_LENGTH, 48'(sb.len_reg));
                send_frame(0);
            end
        end
        no_idle = 1'b0;

        // wider lines: a zero line count saturates to the minimum
        set_config(MODE_REPL, 8'd40, 11'd16, 11'd0,
                   mild_row(), mild_row(), mild_row());
        send_frame(2);

        // more lines over the narrowest line
        set_config(MODE_MIRROR, 8'd0, 11'd3, 11'd8,
                   48'h0020_0020_0020, 48'h0020_0040_0020, 48'h0020_0020_0020);
        send_frame(1);

        stop_sending();
        wait_drained();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/c3bm_pkg.sv
design/c3bm_if.sv
design/c3bm_line_mem.sv
design/c3bm_win_cell.sv
design/c3bm_filter.sv
design/conv2d_3x3_border_modes.sv
tb/sv/tb_top.sv
